// ===== rtl/core/gfa_pkg.sv =====
// shared types, constants and field arithmetic for the gf(2^n) alu
package gfa_pkg;

    localparam int MAX_DEGREE = 8;
    localparam int FIELD_W    = 8;
    localparam int DEGREE_W   = 4;
    localparam int DEGC_W     = $clog2(MAX_DEGREE + 1);
    localparam int CNT_W      = $clog2(MAX_DEGREE);
    localparam int LANE_W     = (MAX_DEGREE > 4) ? 4 : MAX_DEGREE - 1;
    localparam int LANES      = 1 << LANE_W;
    localparam int GRP_W      = MAX_DEGREE - LANE_W;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET  = DEGREE_W'(8);
    localparam logic [FIELD_W-1:0]  MODULUS_RESET = FIELD_W'(27);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic REG_DEGREE  = 1'b0;
    localparam logic REG_MODULUS = 1'b1;

    typedef logic [MAX_DEGREE-1:0] elem_t;
    typedef logic [DEGC_W-1:0]     deg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] operand_a;
        logic [FIELD_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic [FIELD_W-1:0] inverse_of_b;
        logic               no_inverse;
    } out_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COLS,
        S_SCAN,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic col_step;
        logic scan_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_div;
        logic cols_done;
        logic scan_hit;
        logic scan_last;
    } dp_sts_t;

    function automatic elem_t to_elem(input logic [FIELD_W-1:0] v);
        logic [MAX_DEGREE+FIELD_W-1:0] ext;
        ext = {{MAX_DEGREE{1'b0}}, v};
        return ext[MAX_DEGREE-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input elem_t e);
        logic [MAX_DEGREE+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, e};
        return ext[FIELD_W-1:0];
    endfunction

    function automatic deg_t eff_degree(input logic [DEGREE_W-1:0] d);
        deg_t n;
        if (d == '0) begin
            n = DEGC_W'(1);
        end else if (int'(d) > MAX_DEGREE) begin
            n = DEGC_W'(MAX_DEGREE);
        end else begin
            n = DEGC_W'(d);
        end
        return n;
    endfunction

    function automatic elem_t degree_mask(input deg_t n);
        elem_t m;
        for (int i = 0; i < MAX_DEGREE; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // multiply by x, then reduce
    function automatic elem_t xtime(input elem_t c, input elem_t modulus, input elem_t mask);
        logic top;
        top = |(c & mask & ~(mask >> 1));
        return ((c << 1) & mask) ^ (top ? modulus : '0);
    endfunction

    function automatic elem_t gf_mul(input elem_t a, input elem_t b, input deg_t n,
                                     input elem_t modulus, input elem_t mask);
        elem_t acc;
        acc = '0;
        for (int i = MAX_DEGREE - 1; i >= 0; i--) begin
            if (i < int'(n)) begin
                acc = xtime(acc, modulus, mask) ^ (b[i] ? a : '0);
            end
        end
        return acc & mask;
    endfunction

endpackage

// ===== rtl/core/gfa_ctrl.sv =====
// sequencing state machine for the gf(2^n) alu
module gfa_ctrl import gfa_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = sts.in_div ? S_COLS : S_FIN;
                end
            end
            S_COLS: begin
                if (sts.cols_done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_hit || sts.scan_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_COLS: begin
                cmd.col_step = !sts.cols_done;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/gfa_dpath.sv =====
// operand registers, column table, parallel inverse scan and result register
module gfa_dpath import gfa_pkg::*; (
    input  logic                aclk,
    input  in_word_t            s_data,
    input  logic [DEGREE_W-1:0] degree,
    input  logic [FIELD_W-1:0]  modulus,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output out_word_t           m_data
);

    logic [1:0]       op_reg;
    elem_t            a_reg;
    elem_t            b_reg;
    deg_t             n_reg;
    elem_t            mask_reg;
    elem_t            mod_reg;
    elem_t            col_reg [MAX_DEGREE];
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic [GRP_W-1:0] grp_reg;
    elem_t            inv_reg;
    logic             found_reg;
    out_word_t        out_reg;

    deg_t      n_in;
    elem_t     mask_in;
    logic      hit;
    elem_t     hit_cand;
    elem_t     mul_b;
    elem_t     prod;
    out_word_t out_next;

    assign n_in    = eff_degree(degree);
    assign mask_in = degree_mask(n_in);
    assign k_next  = k_reg + CNT_W'(1);

    // each lane checks one candidate as a sum of columns b*x^j
    always_comb begin
        elem_t cand;
        elem_t acc;
        hit      = 1'b0;
        hit_cand = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            cand = {grp_reg, LANE_W'(l)};
            acc  = '0;
            for (int j = 0; j < MAX_DEGREE; j++) begin
                acc = acc ^ (cand[j] ? col_reg[j] : '0);
            end
            if ((acc == elem_t'(1)) && ((cand & ~mask_reg) == '0)) begin
                hit      = 1'b1;
                hit_cand = cand;
            end
        end
    end

    assign sts.in_div    = (s_data.action == ACT_DIV);
    assign sts.cols_done = (DEGC_W'(k_reg) == n_reg - DEGC_W'(1));
    assign sts.scan_hit  = hit;
    assign sts.scan_last = (grp_reg == mask_reg[MAX_DEGREE-1:LANE_W]);

    assign mul_b = (op_reg == ACT_DIV) ? inv_reg : b_reg;
    assign prod  = gf_mul(a_reg, mul_b, n_reg, mod_reg, mask_reg);

    always_comb begin
        out_next = '0;
        case (op_reg) inside
            ACT_ADD, ACT_SUB: begin
                out_next.result = to_field(a_reg ^ b_reg);
            end
            ACT_MUL: begin
                out_next.result = to_field(prod);
            end
            ACT_DIV: begin
                out_next.result       = found_reg ? to_field(prod) : '0;
                out_next.inverse_of_b = found_reg ? to_field(inv_reg) : '0;
                out_next.no_inverse   = !found_reg;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_data.action;
            a_reg      <= to_elem(s_data.operand_a) & mask_in;
            b_reg      <= to_elem(s_data.operand_b) & mask_in;
            n_reg      <= n_in;
            mask_reg   <= mask_in;
            mod_reg    <= to_elem(modulus) & mask_in;
            col_reg[0] <= to_elem(s_data.operand_b) & mask_in;
            k_reg      <= '0;
            grp_reg    <= '0;
            inv_reg    <= '0;
            found_reg  <= 1'b0;
        end
        if (cmd.col_step) begin
            col_reg[k_next] <= xtime(col_reg[k_reg], mod_reg, mask_reg);
            k_reg           <= k_next;
        end
        if (cmd.scan_step) begin
            if (hit) begin
                inv_reg   <= hit_cand;
                found_reg <= 1'b1;
            end else begin
                grp_reg <= grp_reg + GRP_W'(1);
            end
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/core/gf2n_field_alu.sv =====
// gf(2^n) polynomial basis alu: add, subtract, multiply and divide
// add, subtract and multiply go from idle to the finish state, which loads the output register once the output is free
// divide first builds the column table (one shift-reduce per cycle), then runs the 16-lane inverse scan
// until a hit or the last candidate group, and then loads the output register in the finish state
// one word in flight; the next is taken once the result sits in the output register
// reset: synchronous active low, degree 8, modulus 0x1b, no word in flight
module gf2n_field_alu import gfa_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_word_t     s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output out_word_t    m_data,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [7:0]   cfg_wdata
);

    logic [DEGREE_W-1:0] degree_reg;
    logic [FIELD_W-1:0]  modulus_reg;
    dp_cmd_t             cmd;
    dp_sts_t             sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg  <= DEGREE_RESET;
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEGREE:  degree_reg  <= cfg_wdata[DEGREE_W-1:0];
                REG_MODULUS: modulus_reg <= cfg_wdata[FIELD_W-1:0];
                default:     degree_reg  <= degree_reg;
            endcase
        end
    end

    gfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gfa_dpath u_dpath (
        .aclk    (aclk),
        .s_data  (s_data),
        .degree  (degree_reg),
        .modulus (modulus_reg),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule
